[src/stl_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the script token lexer.
// No dependencies; compiled first.
package stl_pkg;

   // Size of the token buffer the cut length is bounded by
   localparam int TOKEN_BUFFER_SIZE = 64;
   localparam logic [5:0] CUT_MAX = 6'(TOKEN_BUFFER_SIZE - 1);

   // Byte classes
   localparam logic [7:0] CHAR_SEPARATOR_MAX = 8'd32;
   localparam logic [7:0] CHAR_NEWLINE       = 8'd10;

   // Configuration register reset values
   localparam logic [7:0] COMMENT_CHAR_RESET = 8'd59;
   localparam logic [7:0] QUOTE_CHAR_RESET   = 8'd34;
   localparam logic [5:0] MAX_CHARS_RESET    = 6'd63;

   // Results one word can cause
   localparam int MAX_RESULTS = 3;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_COMMENT_CHAR = 2'd0,
      CSR_QUOTE_CHAR   = 2'd1,
      CSR_MAX_CHARS    = 2'd2
   } csr_index_type;

   // Lexer mode; codes 5..7 are never entered and act as between tokens
   typedef enum logic [2:0] {
      LEX_BETWEEN = 3'd0,
      LEX_COMMENT = 3'd1,
      LEX_PLAIN   = 3'd2,
      LEX_QUOTED  = 3'd3,
      LEX_DROP    = 3'd4
   } lex_mode_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_CHAR       = 2'd0,
      KIND_END_TOKEN  = 2'd1,
      KIND_END_SCRIPT = 2'd2
   } kind_type;

   // One result word, less the end-of-run flag
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  character;
      logic [5:0]  token_length;
      logic [15:0] line_number;
      logic        crossed_line;
      logic        is_quoted;
   } res_type;

   function automatic res_type make_res(kind_type k, logic [7:0] ch, logic [5:0] len,
                                        logic [15:0] line, logic crossed, logic quoted);
      res_type r;
      r.kind         = k;
      r.character    = ch;
      r.token_length = len;
      r.line_number  = line;
      r.crossed_line = crossed;
      r.is_quoted    = quoted;
      return r;
   endfunction

endpackage

[src/stl_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the script token lexer: script bytes in,
// lexer results out. No dependencies.
interface stl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       first_byte;
   logic       last_byte;

   modport source (output valid, output byte_value, output first_byte, output last_byte,
                   input ready);
   modport sink (input valid, input byte_value, input first_byte, input last_byte,
                 output ready);
endinterface

interface stl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  character;
   logic [5:0]  token_length;
   logic [15:0] line_number;
   logic        crossed_line;
   logic        is_quoted;
   logic        last_of_run;

   modport source (output valid, output kind, output character, output token_length,
                   output line_number, output crossed_line, output is_quoted,
                   output last_of_run, input ready);
   modport sink (input valid, input kind, input character, input token_length,
                 input line_number, input crossed_line, input is_quoted,
                 input last_of_run, output ready);
endinterface

[src/script_token_lexer_top.sv]
`timescale 1ns / 1ps
// Script token lexer: takes one script byte per word on req_bus and emits token
// characters, end-of-token marks and an end-of-script mark on rsp_bus. A byte is
// lexed in the cycle it is accepted and its one to three results are loaded into
// a three-entry result register that drains one word per cycle while rsp_bus is
// ready; a byte that gives no result leaves nothing behind. Throughput is one byte
// per cycle while each byte gives at most one result and rsp_bus is ready; a byte
// giving more results holds the input until its last result is being taken.
// Results appear in the cycle after the accept. Depends on stl_pkg and stl_if.
module script_token_lexer_top (
   input  logic        clock,
   input  logic        reset,
   stl_req_if.sink     req_bus,
   stl_rsp_if.source   rsp_bus,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import stl_pkg::*;

   // Configuration registers
   logic [7:0]   comment_char_ff;
   logic [7:0]   quote_char_ff;
   logic [5:0]   max_chars_ff;

   // Lexer state
   lex_mode_type mode_ff, mode_in;
   logic [5:0]   cc_ff, cc_in;
   logic [15:0]  line_ff, line_in;
   logic         nl_ff, nl_in;

   // Result buffer
   res_type      res_ff [MAX_RESULTS];
   res_type      res_in [MAX_RESULTS];
   logic [1:0]   cnt_ff;
   logic [1:0]   n_in;

   logic         req_fire;
   logic         rsp_fire;

   assign rsp_fire      = rsp_bus.valid && rsp_bus.ready;
   assign req_bus.ready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_bus.ready);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         comment_char_ff <= COMMENT_CHAR_RESET;
         quote_char_ff   <= QUOTE_CHAR_RESET;
         max_chars_ff    <= MAX_CHARS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COMMENT_CHAR: comment_char_ff <= csr_wdata;
            CSR_QUOTE_CHAR:   quote_char_ff   <= csr_wdata;
            CSR_MAX_CHARS:    max_chars_ff    <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // Lex one byte: next state and the results it causes
   always_comb begin
      logic [7:0] b;
      logic       last;
      logic       betw;
      logic       add;
      logic       addq;
      logic       sep;
      logic [5:0] lim;

      b     = req_bus.byte_value;
      last  = req_bus.last_byte;
      betw  = 1'b0;
      add   = 1'b0;
      addq  = 1'b0;
      sep   = (b <= CHAR_SEPARATOR_MAX);

      mode_in = mode_ff;
      cc_in   = cc_ff;
      line_in = line_ff;
      nl_in   = nl_ff;
      n_in    = 2'd0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res_in[i] = '0;
      end

      // Clamp the cut length
      lim = (max_chars_ff == 6'd0) ? 6'd1 : max_chars_ff;
      if (lim > CUT_MAX) begin
         lim = CUT_MAX;
      end

      // Start of a new script drops any unfinished token
      if (req_bus.first_byte) begin
         mode_in = LEX_BETWEEN;
         cc_in   = 6'd0;
         line_in = 16'd1;
         nl_in   = 1'b0;
      end

      unique case (mode_in)
         LEX_COMMENT: begin
            if (b == CHAR_NEWLINE) begin
               if (line_in != 16'hFFFF) line_in = line_in + 16'd1;
               nl_in   = 1'b1;
               mode_in = LEX_BETWEEN;
            end
         end
         LEX_PLAIN: begin
            if (!sep && (b != comment_char_ff)) begin
               add = 1'b1;
            end else begin
               res_in[n_in] = make_res(KIND_END_TOKEN, 8'd0, cc_in, line_in, nl_in, 1'b0);
               n_in    = n_in + 2'd1;
               cc_in   = 6'd0;
               nl_in   = 1'b0;
               mode_in = LEX_BETWEEN;
               betw    = 1'b1;
            end
         end
         LEX_QUOTED: begin
            if (b == quote_char_ff) begin
               res_in[n_in] = make_res(KIND_END_TOKEN, 8'd0, cc_in, line_in, nl_in, 1'b1);
               n_in    = n_in + 2'd1;
               cc_in   = 6'd0;
               nl_in   = 1'b0;
               mode_in = LEX_BETWEEN;
            end else begin
               add  = 1'b1;
               addq = 1'b1;
            end
         end
         LEX_DROP: mode_in = LEX_BETWEEN;
         default: begin
            mode_in = LEX_BETWEEN;
            betw    = 1'b1;
         end
      endcase

      // Byte seen between tokens
      if (betw) begin
         if (sep) begin
            if (b == CHAR_NEWLINE) begin
               if (line_in != 16'hFFFF) line_in = line_in + 16'd1;
               nl_in = 1'b1;
            end
         end else if (b == comment_char_ff) begin
            mode_in = LEX_COMMENT;
         end else if (b == quote_char_ff) begin
            mode_in = LEX_QUOTED;
            cc_in   = 6'd0;
            if (last) begin
               res_in[n_in] = make_res(KIND_END_TOKEN, 8'd0, cc_in, line_in, nl_in, 1'b1);
               n_in    = n_in + 2'd1;
               nl_in   = 1'b0;
               mode_in = LEX_BETWEEN;
            end
         end else begin
            mode_in = LEX_PLAIN;
            cc_in   = 6'd0;
            add     = 1'b1;
         end
      end

      // Append a token character, cutting at the limit
      if (add) begin
         cc_in = cc_in + 6'd1;
         res_in[n_in] = make_res(KIND_CHAR, b, cc_in, line_in, nl_in, addq);
         n_in = n_in + 2'd1;
         if (last || (cc_in >= lim)) begin
            res_in[n_in] = make_res(KIND_END_TOKEN, 8'd0, cc_in, line_in, nl_in, addq);
            n_in    = n_in + 2'd1;
            cc_in   = 6'd0;
            nl_in   = 1'b0;
            mode_in = (addq && !last) ? LEX_DROP : LEX_BETWEEN;
         end
      end

      // Close the script
      if (last) begin
         res_in[n_in] = make_res(KIND_END_SCRIPT, 8'd0, 6'd0, line_in, nl_in, 1'b0);
         n_in    = n_in + 2'd1;
         mode_in = LEX_BETWEEN;
         cc_in   = 6'd0;
         nl_in   = 1'b0;
      end
   end

   // Advance lexer state on an accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= LEX_BETWEEN;
         cc_ff   <= 6'd0;
         line_ff <= 16'd1;
         nl_ff   <= 1'b0;
      end else if (req_fire) begin
         mode_ff <= mode_in;
         cc_ff   <= cc_in;
         line_ff <= line_in;
         nl_ff   <= nl_in;
      end
   end

   // Hold, load and drain the result buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (req_fire) begin
         cnt_ff <= n_in;
      end else if (rsp_fire) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            res_ff[i] <= res_in[i];
         end
      end else if (rsp_fire) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            res_ff[i] <= res_ff[i + 1];
         end
      end
   end

   // Drive the result port from the head entry
   always_comb begin
      rsp_bus.valid        = (cnt_ff != 2'd0);
      rsp_bus.kind         = res_ff[0].kind;
      rsp_bus.character    = res_ff[0].character;
      rsp_bus.token_length = res_ff[0].token_length;
      rsp_bus.line_number  = res_ff[0].line_number;
      rsp_bus.crossed_line = res_ff[0].crossed_line;
      rsp_bus.is_quoted    = res_ff[0].is_quoted;
      rsp_bus.last_of_run  = (cnt_ff == 2'd1);
   end

   // Outside a token the character count is always clear
   a_count_clear: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == LEX_BETWEEN || mode_ff == LEX_COMMENT || mode_ff == LEX_DROP)
         |-> (cc_ff == 6'd0))
      else $error("character count set outside a token");

   // Line count never falls to zero
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != 16'd0)
      else $error("line count is zero");

   // A last byte always yields results and leaves the lexer between tokens
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_bus.last_byte)
         |=> (rsp_bus.valid && mode_ff == LEX_BETWEEN && !nl_ff))
      else $error("last byte did not close the script");

   // The final word of a run after a last byte is the end-of-script mark
   a_eos_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind == KIND_END_SCRIPT)
         |-> (rsp_bus.last_of_run && rsp_bus.token_length == 6'd0 && !rsp_bus.is_quoted))
      else $error("end-of-script mark out of place");

endmodule

[test/script_token_lexer_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for script_token_lexer_top: directed and random script bytes
// with random idling on both channels, checked against an in-bench lexer tracker.
// Depends on stl_pkg, stl_if and the lexer top level.
module script_token_lexer_top_tb;
   import stl_pkg::*;

   // One expected result word with its end-of-run flag
   typedef struct {
      res_type r;
      logic    last;
   } result_word_type;

   // Tracks lexer state and registers, and queues the words each accepted byte should produce
   class lexer_tracker;
      result_word_type expected_words[$];
      result_word_type byte_words[$];
      logic [7:0]      comment_ch;
      logic [7:0]      quote_ch;
      logic [5:0]      max_chars;
      lex_mode_type    mode;
      logic [5:0]      count;
      logic [15:0]     line;
      logic            nl_seen;
      int              errors;

      function new();
         comment_ch = COMMENT_CHAR_RESET;
         quote_ch   = QUOTE_CHAR_RESET;
         max_chars  = MAX_CHARS_RESET;
         mode       = LEX_BETWEEN;
         count      = '0;
         line       = 16'd1;
         nl_seen    = 1'b0;
         errors     = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [7:0] val);
         case (idx)
            CSR_COMMENT_CHAR: comment_ch = val;
            CSR_QUOTE_CHAR:   quote_ch = val;
            CSR_MAX_CHARS:    max_chars = val[5:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // Queue one word for the current byte; a byte never gives more than three
      function void emit(kind_type k, logic [7:0] ch, logic [5:0] len, logic q);
         result_word_type w;
         if (byte_words.size() < MAX_RESULTS) begin
            w.r.kind         = k;
            w.r.character    = ch;
            w.r.token_length = len;
            w.r.line_number  = line;
            w.r.crossed_line = nl_seen;
            w.r.is_quoted    = q;
            w.last           = 1'b0;
            byte_words.push_back(w);
         end
      endfunction

      // Count a newline, holding at the top of the range
      function void bump_line();
         if (line != 16'hFFFF) line++;
         nl_seen = 1'b1;
      endfunction

      function void end_token(logic q);
         emit(KIND_END_TOKEN, 8'd0, count, q);
         count   = '0;
         nl_seen = 1'b0;
         mode    = LEX_BETWEEN;
      endfunction

      // Append a character; cut the token at the limit, and drop one byte after a cut quote
      function void add_char(logic [7:0] b, logic q, logic last);
         logic [5:0] lim;
         lim   = (max_chars == 0) ? 6'd1 : max_chars;
         count = count + 6'd1;
         emit(KIND_CHAR, b, count, q);
         if (last || count >= lim) begin
            end_token(q);
            if (q && !last) mode = LEX_DROP;
         end
      endfunction

      // Classify a byte seen between tokens: separator, comment, quote, then plain
      function void open_between(logic [7:0] b, logic last);
         if (b <= CHAR_SEPARATOR_MAX) begin
            if (b == CHAR_NEWLINE) bump_line();
         end else if (b == comment_ch) begin
            mode = LEX_COMMENT;
         end else if (b == quote_ch) begin
            mode  = LEX_QUOTED;
            count = '0;
            if (last) end_token(1'b1);
         end else begin
            mode  = LEX_PLAIN;
            count = '0;
            add_char(b, 1'b0, last);
         end
      endfunction

      function void lex_byte(logic [7:0] b, logic first, logic last);
         result_word_type tail;
         if (first) begin
            mode    = LEX_BETWEEN;
            count   = '0;
            line    = 16'd1;
            nl_seen = 1'b0;
         end
         byte_words.delete();
         case (mode)
            LEX_COMMENT: begin
               if (b == CHAR_NEWLINE) begin
                  bump_line();
                  mode = LEX_BETWEEN;
               end
            end
            LEX_PLAIN: begin
               if (b > CHAR_SEPARATOR_MAX && b != comment_ch) begin
                  add_char(b, 1'b0, last);
               end else begin
                  end_token(1'b0);
                  open_between(b, last);
               end
            end
            LEX_QUOTED: begin
               if (b == quote_ch) end_token(1'b1);
               else add_char(b, 1'b1, last);
            end
            LEX_DROP: mode = LEX_BETWEEN;
            default: begin
               mode = LEX_BETWEEN;
               open_between(b, last);
            end
         endcase
         if (last) begin
            emit(KIND_END_SCRIPT, 8'd0, 6'd0, 1'b0);
            mode    = LEX_BETWEEN;
            count   = '0;
            nl_seen = 1'b0;
         end
         // Flag the final word of this byte and hand the run to the store
         if (byte_words.size() > 0) begin
            tail      = byte_words.pop_back();
            tail.last = 1'b1;
            byte_words.push_back(tail);
         end
         foreach (byte_words[i]) expected_words.push_back(byte_words[i]);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_word(logic [1:0] kind, logic [7:0] ch, logic [5:0] len,
                               logic [15:0] line_no, logic crossed, logic quoted,
                               logic last);
         result_word_type w;
         if (expected_words.size() == 0) begin
            $error("unexpected result word: kind %0d character %0d", kind, ch);
            errors++;
            return;
         end
         w = expected_words.pop_front();
         compare_field("kind", w.r.kind, kind);
         compare_field("character", w.r.character, ch);
         compare_field("token_length", w.r.token_length, len);
         compare_field("line_number", w.r.line_number, line_no);
         compare_field("crossed_line", w.r.crossed_line, crossed);
         compare_field("is_quoted", w.r.is_quoted, quoted);
         compare_field("last_of_run", w.last, last);
      endfunction
   endclass

   localparam int         STALL_LIMIT   = 2000;
   localparam int         DRAIN_CYCLES  = 4;
   localparam int         PHASE_ITEMS   = 100;
   localparam logic [1:0] CSR_UNUSED    = 2'd3;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [7:0]  csr_wdata;

   int          send_idle_pct;
   int          rcv_stall_pct;
   int          items_sent;
   int          stall_cycles;
   logic [7:0]  script_bytes[$];
   lexer_tracker tracker;

   stl_req_if req_bus ();
   stl_rsp_if rsp_bus ();

   script_token_lexer_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Check accepted words, drive receiver stalls and count cycles with no handshake
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         tracker.check_word(rsp_bus.kind, rsp_bus.character, rsp_bus.token_length,
                            rsp_bus.line_number, rsp_bus.crossed_line, rsp_bus.is_quoted,
                            rsp_bus.last_of_run);
      end
      rsp_bus.ready <= ($urandom_range(99) >= rcv_stall_pct);
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // End the run when nothing moves for too long
   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   // Offer one byte, idling first at the current rate, and hold it until accepted
   task send_byte(logic [7:0] b, logic first, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.byte_value <= b;
      req_bus.first_byte <= first;
      req_bus.last_byte  <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tracker.lex_byte(b, first, last);
      items_sent++;
   endtask

   // Hold the sender until every expected word is in, then let the block settle
   task wait_idle();
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task write_reg(logic [1:0] idx, logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.set_reg(idx, val);
   endtask

   // Build a script from words, separators, comments, quoted tokens and stray bytes
   task build_script(int target);
      int n;
      int sel;
      script_bytes.delete();
      while (script_bytes.size() < target) begin
         sel = $urandom_range(9);
         if (sel <= 3) begin
            n = ($urandom_range(7) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 6);
            repeat (n) script_bytes.push_back(8'($urandom_range(33, 255)));
         end else if (sel <= 5) begin
            repeat ($urandom_range(1, 3)) begin
               case ($urandom_range(3))
                  0: script_bytes.push_back(8'd32);
                  1: script_bytes.push_back(CHAR_NEWLINE);
                  2: script_bytes.push_back(8'd9);
                  default: script_bytes.push_back(8'($urandom_range(0, 32)));
               endcase
            end
         end else if (sel == 6) begin
            script_bytes.push_back(tracker.comment_ch);
            repeat ($urandom_range(0, 4)) script_bytes.push_back(8'($urandom_range(0, 255)));
            script_bytes.push_back(CHAR_NEWLINE);
         end else if (sel <= 8) begin
            n = ($urandom_range(7) == 0) ? $urandom_range(1, 70) : $urandom_range(0, 8);
            script_bytes.push_back(tracker.quote_ch);
            repeat (n) script_bytes.push_back(8'($urandom_range(0, 255)));
            script_bytes.push_back(tracker.quote_ch);
         end else begin
            script_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Send the built script; now and then flip a first or last flag
   task send_script();
      logic first;
      logic last;
      foreach (script_bytes[i]) begin
         first = (i == 0);
         last  = (i == script_bytes.size() - 1);
         if ($urandom_range(19) == 0) first = !first;
         if ($urandom_range(19) == 0) last = !last;
         send_byte(script_bytes[i], first, last);
      end
   endtask

   initial begin
      int  phase_start;
      int  phase;
      logic paused;
      tracker       = new();
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      items_sent    = 0;
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= CSR_COMMENT_CHAR;
      csr_wdata          <= 8'd0;
      req_bus.valid      <= 1'b0;
      req_bus.byte_value <= 8'd0;
      req_bus.first_byte <= 1'b0;
      req_bus.last_byte  <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: tokens, separators, comments, quotes, flags, at reset settings
      send_byte("a", 1'b1, 1'b0);
      send_byte("b", 1'b0, 1'b0);
      send_byte(8'd32, 1'b0, 1'b0);
      send_byte(CHAR_NEWLINE, 1'b0, 1'b0);
      send_byte(COMMENT_CHAR_RESET, 1'b0, 1'b0);
      send_byte("x", 1'b0, 1'b0);
      send_byte(CHAR_NEWLINE, 1'b0, 1'b0);
      send_byte(QUOTE_CHAR_RESET, 1'b0, 1'b0);
      send_byte(CHAR_NEWLINE, 1'b0, 1'b0);
      send_byte("q", 1'b0, 1'b0);
      send_byte(QUOTE_CHAR_RESET, 1'b0, 1'b0);
      // quote inside a plain token, then a comment byte ending it
      send_byte("c", 1'b0, 1'b0);
      send_byte(QUOTE_CHAR_RESET, 1'b0, 1'b0);
      send_byte(COMMENT_CHAR_RESET, 1'b0, 1'b0);
      send_byte(CHAR_NEWLINE, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      // quote on the last byte gives an empty quoted token
      send_byte(QUOTE_CHAR_RESET, 1'b0, 1'b1);
      send_byte("z", 1'b1, 1'b1);
      // continuation after the end, then a new script dropping a token in progress
      send_byte(CHAR_NEWLINE, 1'b0, 1'b0);
      send_byte("m", 1'b0, 1'b0);
      send_byte("n", 1'b1, 1'b0);
      send_byte(CHAR_NEWLINE, 1'b0, 1'b1);

      // Directed: cut tokens at a short limit
      wait_idle();
      write_reg(CSR_MAX_CHARS, 8'd2);
      send_byte(QUOTE_CHAR_RESET, 1'b1, 1'b0);
      send_byte("a", 1'b0, 1'b0);
      send_byte("b", 1'b0, 1'b0);
      send_byte(CHAR_NEWLINE, 1'b0, 1'b0);
      send_byte("c", 1'b0, 1'b0);
      send_byte("d", 1'b0, 1'b0);
      send_byte("e", 1'b0, 1'b1);

      // Random scripts over several register settings and idling mixes
      for (phase = 0; phase < 4; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               send_idle_pct = 0;
               rcv_stall_pct = 0;
               write_reg(CSR_COMMENT_CHAR, COMMENT_CHAR_RESET);
               write_reg(CSR_QUOTE_CHAR, QUOTE_CHAR_RESET);
               write_reg(CSR_MAX_CHARS, 8'(MAX_CHARS_RESET));
               write_reg(CSR_UNUSED, 8'hFF);
            end
            1: begin
               send_idle_pct = 85;
               rcv_stall_pct = 0;
               write_reg(CSR_COMMENT_CHAR, 8'd0);
               write_reg(CSR_QUOTE_CHAR, 8'd255);
               write_reg(CSR_MAX_CHARS, 8'd1);
            end
            2: begin
               send_idle_pct = 0;
               rcv_stall_pct = 85;
               // comment and quote share one byte: comment wins between tokens
               write_reg(CSR_COMMENT_CHAR, 8'd64);
               write_reg(CSR_QUOTE_CHAR, 8'd64);
               write_reg(CSR_MAX_CHARS, 8'($urandom_range(2, 6)));
            end
            default: begin
               send_idle_pct = 10;
               rcv_stall_pct = 10;
               write_reg(CSR_COMMENT_CHAR, 8'd255);
               write_reg(CSR_QUOTE_CHAR, 8'($urandom_range(33, 254)));
               write_reg(CSR_MAX_CHARS, 8'($urandom_range(7, 40)));
            end
         endcase
         phase_start = items_sent;
         paused      = 1'b0;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            // hold the sender once per phase until the results drain
            if (!paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
               wait_idle();
               paused = 1'b1;
            end
            build_script($urandom_range(1, 24));
            send_script();
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

[files.f]
src/stl_pkg.sv
src/stl_if.sv
src/script_token_lexer_top.sv
test/script_token_lexer_top_tb.sv
